FILE: rtl/per_channel_median_range_tracker_assert.svh
// Assertion macros for the median range tracker.
// Included by the top level; no other dependencies.
`ifndef PER_CHANNEL_MEDIAN_RANGE_TRACKER_ASSERT_SVH
`define PER_CHANNEL_MEDIAN_RANGE_TRACKER_ASSERT_SVH
`define PMRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PMRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/pmrt_pkg.sv
// Package for the median range tracker: widths, constants, state codes
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmrt_pkg;
    localparam int CHANNELS_DEF = 8;
    localparam int WINDOW_DEF   = 21;
    localparam int POS_W        = 12;
    localparam int ACT_W        = 24;
    localparam int CFG_W        = 4;
    localparam int ID_W         = 4;
    localparam logic [ACT_W-1:0] ACT_MAX  = {ACT_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam logic [CFG_W-1:0] CFG_RST  = 4'd8;
    localparam logic [ID_W-1:0]  ID_MAX   = 4'd15;
    localparam logic [1:0] ADDR_CHANNELS_IN_USE = 2'd0;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DONE  = 6'b001000,
        S_PICK  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic store_wr;   // write the sample into the window
        logic sel_start;  // start a selection pass
        logic sel_step;   // advance the selection pointer
        logic sel_commit; // finish one rank of the selection
        logic med_update; // apply the median to channel state
        logic pick_start;
        logic pick_step;
        logic pick_commit;
        logic out_load;   // capture the result
    } t_cmd;

    typedef struct packed {
        logic full;       // this sample completes a window
        logic accepted;   // channel takes the sample
        logic sel_last;   // last element of the current pass
        logic sel_done;   // all ranks up to the median chosen
        logic pick_last;  // last channel scanned
    } t_sts;
endpackage
`default_nettype wire

FILE: rtl/pmrt_ctrl.sv
// Controller state machine for the median range tracker.
// Depends on pmrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmrt_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_mode,
    input  wire              i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output pmrt_pkg::t_cmd   o_cmd,
    input  pmrt_pkg::t_sts   i_sts
);
    import pmrt_pkg::*;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                    if (i_mode) begin
                        o_cmd.pick_start = 1'b1;
                        n_state = S_PICK;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.store_wr = i_sts.accepted;
                if (i_sts.accepted && i_sts.full) begin
                    o_cmd.sel_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.sel_step = 1'b1;
                if (i_sts.sel_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.sel_commit = 1'b1;
                if (i_sts.sel_done) begin
                    o_cmd.med_update = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_PICK: begin
                o_cmd.pick_step = 1'b1;
                if (i_sts.pick_last) begin
                    o_cmd.pick_commit = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pmrt_dp.sv
// Datapath for the median range tracker: window memory, selection unit,
// per-channel marks and activity, pick scan. Depends on pmrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pmrt_dp #(
    parameter int CHANNELS = pmrt_pkg::CHANNELS_DEF,
    parameter int WINDOW   = pmrt_pkg::WINDOW_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_take,
    input  wire                          i_mode,
    input  wire  [2:0]                   i_channel,
    input  wire  [pmrt_pkg::POS_W-1:0]   i_sample,
    input  wire  [pmrt_pkg::CFG_W-1:0]   i_cfg_ch,
    input  pmrt_pkg::t_cmd               i_cmd,
    output pmrt_pkg::t_sts               o_sts,
    output logic [2:0]                   o_out_channel,
    output logic                         o_median_valid,
    output logic [pmrt_pkg::POS_W-1:0]   o_median,
    output logic [pmrt_pkg::POS_W-1:0]   o_range_low,
    output logic [pmrt_pkg::POS_W-1:0]   o_range_high,
    output logic [pmrt_pkg::ACT_W-1:0]   o_activity,
    output logic                         o_picked,
    output logic [2:0]                   o_given_id
);
    import pmrt_pkg::*;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHC_W = $clog2(CHANNELS + 1);
    localparam int WI_W  = $clog2(WINDOW);
    localparam int FL_W  = $clog2(WINDOW + 1);
    localparam int MEM_D = CHANNELS * WINDOW;
    localparam int MA_W  = $clog2(MEM_D);
    localparam int RANK  = WINDOW / 2;

    // window memory: one write and one read per cycle, registered read
    logic [POS_W-1:0] r_mem [MEM_D];
    logic [POS_W-1:0] r_rd;
    // selection: removed marks over window positions
    logic [WINDOW-1:0] r_used;
    logic [WI_W-1:0]   r_rd_idx;   // index being read
    logic              r_rd_ok;    // r_rd holds entry r_cmp_idx
    logic [WI_W-1:0]   r_cmp_idx;
    logic [POS_W-1:0]  r_best;
    logic [WI_W-1:0]   r_best_idx;
    logic              r_best_ok;
    logic [WI_W-1:0]   r_rank;

    logic              r_mode;
    logic [2:0]        r_chan;
    logic [POS_W-1:0]  r_sample;
    logic [FL_W-1:0]   r_fill [CHANNELS];
    logic [POS_W-1:0]  r_low  [CHANNELS];
    logic [POS_W-1:0]  r_high [CHANNELS];
    logic [POS_W-1:0]  r_last [CHANNELS];
    logic [CHANNELS-1:0] r_seen;
    logic [ACT_W-1:0]  r_act  [CHANNELS];
    logic [CHANNELS-1:0] r_asg;
    logic [ID_W-1:0]   r_next_id;

    logic [CHC_W-1:0]  r_pk_idx;
    logic [CH_W-1:0]   r_pk_cand;
    logic [ACT_W-1:0]  r_pk_best;
    logic              r_pk_found;
    logic [2:0]        r_gid;
    logic              r_median_valid;
    logic [POS_W-1:0]  r_median;

    logic [CHC_W-1:0]  w_n;
    logic              w_in_range;
    logic [CH_W-1:0]   w_ch;
    logic [FL_W-1:0]   w_f;
    logic [MA_W-1:0]   w_base;
    logic              w_sel_last;
    logic [CH_W-1:0]   w_pk_ch;

    always_comb begin
        if ({{(32-CFG_W){1'b0}}, i_cfg_ch} > CHANNELS) begin
            w_n = CHC_W'(CHANNELS);
        end else begin
            w_n = CHC_W'(i_cfg_ch);
        end
    end
    assign w_ch       = CH_W'(r_chan);
    assign w_in_range = ({29'd0, r_chan} < CHANNELS);
    assign w_f        = (r_fill[w_ch] >= FL_W'(WINDOW)) ? '0 : r_fill[w_ch];
    assign w_base     = MA_W'(w_ch * WINDOW);
    assign w_sel_last = r_rd_ok && (r_cmp_idx == WI_W'(WINDOW - 1));
    assign w_pk_ch    = CH_W'(r_pk_idx);

    assign o_sts.accepted = w_in_range && ({29'd0, r_chan} < 32'(w_n)) && !r_asg[w_ch];
    assign o_sts.full     = (w_f == FL_W'(WINDOW - 1));
    assign o_sts.sel_last = w_sel_last;
    assign o_sts.sel_done = (r_rank == WI_W'(RANK));
    assign o_sts.pick_last = (r_pk_idx >= CHC_W'(CHANNELS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_mem[w_base + MA_W'(w_f)] <= r_sample;
        end
        r_rd <= r_mem[w_base + MA_W'(r_rd_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_mode   <= i_mode;
            r_chan   <= i_channel;
            r_sample <= i_sample;
        end
        if (i_cmd.sel_start || i_cmd.sel_commit) begin
            r_rd_idx  <= '0;
            r_rd_ok   <= 1'b0;
            r_best_ok <= 1'b0;
        end else if (i_cmd.sel_step) begin
            if (r_rd_idx != WI_W'(WINDOW - 1)) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            r_rd_ok   <= 1'b1;
            r_cmp_idx <= r_rd_idx;
            if (r_rd_ok && !r_used[r_cmp_idx]
                && (!r_best_ok || r_rd < r_best)) begin
                r_best     <= r_rd;
                r_best_idx <= r_cmp_idx;
                r_best_ok  <= 1'b1;
            end
        end
        if (i_cmd.sel_start) begin
            r_used <= '0;
            r_rank <= '0;
        end else if (i_cmd.sel_commit) begin
            r_used[r_best_idx] <= 1'b1;
            r_rank <= r_rank + 1'b1;
        end
        if (i_cmd.pick_start) begin
            r_pk_idx   <= '0;
            r_pk_best  <= '0;
            r_pk_cand  <= '0;
            r_pk_found <= 1'b0;
        end else if (i_cmd.pick_step) begin
            r_pk_idx <= r_pk_idx + 1'b1;
            if (r_pk_idx < w_n && !r_asg[w_pk_ch] && r_act[w_pk_ch] > r_pk_best) begin
                r_pk_best  <= r_act[w_pk_ch];
                r_pk_cand  <= w_pk_ch;
                r_pk_found <= 1'b1;
            end
        end
    end

    // final pick compare folds in the last channel combinationally
    logic             w_pf;
    logic [CH_W-1:0]  w_pc;
    logic [ACT_W-1:0] w_pb;
    always_comb begin
        w_pf = r_pk_found;
        w_pc = r_pk_cand;
        w_pb = r_pk_best;
        if (r_pk_idx < w_n && !r_asg[w_pk_ch] && r_act[w_pk_ch] > r_pk_best) begin
            w_pf = 1'b1;
            w_pc = w_pk_ch;
            w_pb = r_act[w_pk_ch];
        end
    end

    logic [ACT_W:0]   w_sum;
    logic [POS_W-1:0] w_diff;
    assign w_diff = (r_best > r_last[w_ch]) ? (r_best - r_last[w_ch])
                                            : (r_last[w_ch] - r_best);
    assign w_sum  = {1'b0, r_act[w_ch]} + {{(ACT_W-POS_W+1){1'b0}}, w_diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill[c] <= '0;
                r_low[c]  <= POS_MAX;
                r_high[c] <= '0;
                r_last[c] <= '0;
                r_act[c]  <= '0;
            end
            r_seen    <= '0;
            r_asg     <= '0;
            r_next_id <= '0;
        end else begin
            if (i_cmd.store_wr) begin
                r_fill[w_ch] <= o_sts.full ? '0 : w_f + 1'b1;
            end
            if (i_cmd.med_update) begin
                if (r_best < r_low[w_ch])  r_low[w_ch]  <= r_best;
                if (r_best > r_high[w_ch]) r_high[w_ch] <= r_best;
                if (r_seen[w_ch]) begin
                    r_act[w_ch] <= w_sum[ACT_W] ? ACT_MAX : w_sum[ACT_W-1:0];
                end
                r_last[w_ch] <= r_best;
                r_seen[w_ch] <= 1'b1;
            end
            if (i_cmd.pick_commit) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_act[c] <= '0;
                end
                if (w_pf) begin
                    r_asg[w_pc] <= 1'b1;
                    if (r_next_id < ID_MAX) r_next_id <= r_next_id + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_median_valid <= 1'b0;
        end else if (i_cmd.med_update) begin
            r_median_valid <= 1'b1;
            r_median       <= r_best;
        end
        if (i_cmd.out_load) begin
            o_median_valid <= 1'b0;
            o_median       <= '0;
            o_picked       <= 1'b0;
            o_given_id     <= '0;
            o_out_channel  <= '0;
            o_range_low    <= '0;
            o_range_high   <= '0;
            o_activity     <= '0;
            if (!r_mode) begin
                o_out_channel <= r_chan;
                if (r_median_valid) begin
                    o_median_valid <= 1'b1;
                    o_median       <= r_median;
                end
                if (w_in_range) begin
                    o_range_low  <= r_low[w_ch];
                    o_range_high <= r_high[w_ch];
                    o_activity   <= r_act[w_ch];
                end
            end else if (r_pk_found) begin
                o_picked      <= 1'b1;
                o_out_channel <= 3'(r_pk_cand);
                o_range_low   <= r_low[r_pk_cand];
                o_range_high  <= r_high[r_pk_cand];
                o_activity    <= r_pk_best;
                o_given_id    <= r_gid;
            end
        end
    end

    // id given is captured at pick commit to survive saturation
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_commit) begin
            r_gid <= r_next_id[2:0];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/per_channel_median_range_tracker.sv
// Top level of the median range tracker: controller, datapath and APB
// register. Depends on pmrt_pkg, pmrt_ctrl, pmrt_dp and the assertion header.
// A sample passes the accept, load and output steps from its transfer until
// the input is free again; one that completes a window adds WINDOW/2+1
// selection passes, each a scan of the window through the window memory
// read port. A pick scans the channels one per cycle, then outputs its
// result. One item is in work at a time; a result held by an output stall
// holds the next result in the output state.
`timescale 1ns / 1ps
`default_nettype none
module per_channel_median_range_tracker #(
    parameter int CHANNELS = pmrt_pkg::CHANNELS_DEF,
    parameter int WINDOW   = pmrt_pkg::WINDOW_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_mode,
    input  wire  [2:0]                  i_channel,
    input  wire  [pmrt_pkg::POS_W-1:0]  i_sample,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [2:0]                  o_out_channel,
    output logic                        o_median_valid,
    output logic [pmrt_pkg::POS_W-1:0]  o_median,
    output logic [pmrt_pkg::POS_W-1:0]  o_range_low,
    output logic [pmrt_pkg::POS_W-1:0]  o_range_high,
    output logic [pmrt_pkg::ACT_W-1:0]  o_activity,
    output logic                        o_picked,
    output logic [2:0]                  o_given_id,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [1:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pmrt_pkg::*;
    `include "per_channel_median_range_tracker_assert.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic [CFG_W-1:0] r_cfg;
    logic w_take;
    logic [2:0] w_gid;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CHANNELS_IN_USE) ? {28'd0, r_cfg} : 32'd0;
    assign w_take = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_CHANNELS_IN_USE) begin
            r_cfg <= pwdata[CFG_W-1:0];
        end
    end

    pmrt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_mode, .i_out_stall,
        .o_in_stall, .o_out_valid, .o_cmd(w_cmd), .i_sts(w_sts)
    );

    pmrt_dp #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_dp (
        .i_clk, .i_rst_n, .i_take(w_take), .i_mode, .i_channel, .i_sample,
        .i_cfg_ch(r_cfg), .i_cmd(w_cmd), .o_sts(w_sts), .o_out_channel,
        .o_median_valid, .o_median, .o_range_low, .o_range_high, .o_activity,
        .o_picked, .o_given_id(w_gid)
    );
    assign o_given_id = w_gid;

    `PMRT_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, o_in_stall, !w_take)
    `PMRT_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, w_take, o_in_stall)
    `PMRT_ASSERT_IMPL(a_pick_flag, i_clk, i_rst_n, o_out_valid && o_picked, !o_median_valid)
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for per_channel_median_range_tracker: directed table, then random
// samples and picks, checked against an in-bench predictor. Depends on pmrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import pmrt_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam int WIN = WINDOW_DEF;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_PICK   = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SEG_ITEMS = 305;

    typedef struct packed {
        logic [2:0]       chan;
        logic             med_ok;
        logic [POS_W-1:0] med;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [ACT_W-1:0] act;
        logic             picked;
        logic [2:0]       id;
    } t_tracker_result;

    typedef struct {
        bit               is_cfg;
        logic             mode;
        logic [2:0]       chan;
        logic [POS_W-1:0] smp;
        int               reps;
        bit               typed;
        t_tracker_result  res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_mode = 1'b0;
    logic [2:0] i_channel = '0;
    logic [POS_W-1:0] i_sample = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [2:0] o_out_channel;
    logic o_median_valid;
    logic [POS_W-1:0] o_median, o_range_low, o_range_high;
    logic [ACT_W-1:0] o_activity;
    logic o_picked;
    logic [2:0] o_given_id;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    per_channel_median_range_tracker dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [POS_W-1:0] win_data [NCH][WIN];
    int               win_fill [NCH];
    logic [POS_W-1:0] low_pos [NCH];
    logic [POS_W-1:0] high_pos [NCH];
    logic [POS_W-1:0] prev_med [NCH];
    bit               med_seen [NCH];
    logic [ACT_W-1:0] act_sum [NCH];
    bit               owned [NCH];
    logic [ID_W-1:0]  id_next;
    logic [CFG_W-1:0] chans_cfg;

    t_tracker_result expected_results[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    function automatic logic [POS_W-1:0] window_median(int c);
        int lt, le;
        for (int i = 0; i < WIN; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < WIN; j++) begin
                if (win_data[c][j] < win_data[c][i]) lt++;
                if (win_data[c][j] <= win_data[c][i]) le++;
            end
            if (lt <= WIN / 2 && WIN / 2 < le) return win_data[c][i];
        end
        return '0;
    endfunction

    function automatic t_tracker_result track_item(logic mode, logic [2:0] c,
                                                   logic [POS_W-1:0] smp);
        t_tracker_result r;
        int n, cand;
        logic [ACT_W-1:0] best;
        logic [POS_W-1:0] m, d;
        logic [ACT_W:0] s;
        r = '0;
        n = (chans_cfg > NCH) ? NCH : chans_cfg;
        if (mode == MODE_SAMPLE) begin
            r.chan = c;
            if (c < n && !owned[c]) begin
                win_data[c][win_fill[c]] = smp;
                win_fill[c]++;
                if (win_fill[c] >= WIN) begin
                    m = window_median(c);
                    if (m < low_pos[c]) low_pos[c] = m;
                    if (m > high_pos[c]) high_pos[c] = m;
                    if (med_seen[c]) begin
                        d = (m > prev_med[c]) ? m - prev_med[c] : prev_med[c] - m;
                        s = act_sum[c] + d;
                        act_sum[c] = (s > ACT_MAX) ? ACT_MAX : s[ACT_W-1:0];
                    end
                    prev_med[c] = m;
                    med_seen[c] = 1'b1;
                    win_fill[c] = 0;
                    r.med_ok = 1'b1;
                    r.med = m;
                end
            end
            r.lo = low_pos[c];
            r.hi = high_pos[c];
            r.act = act_sum[c];
        end else begin
            cand = -1;
            best = '0;
            for (int i = 0; i < n; i++)
                if (!owned[i] && act_sum[i] > best) begin
                    best = act_sum[i];
                    cand = i;
                end
            for (int i = 0; i < NCH; i++) act_sum[i] = '0;
            if (cand >= 0) begin
                owned[cand] = 1'b1;
                r.chan = cand[2:0];
                r.lo = low_pos[cand];
                r.hi = high_pos[cand];
                r.act = best;
                r.picked = 1'b1;
                r.id = id_next[2:0];
                if (id_next < ID_MAX) id_next++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge i_clk) begin
        t_tracker_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", o_out_channel, 0);
            end else begin
                w = expected_results.pop_front();
                if (o_out_channel !== w.chan) report_mismatch("out_channel", o_out_channel, w.chan);
                if (o_median_valid !== w.med_ok)
                    report_mismatch("median_valid", o_median_valid, w.med_ok);
                if (o_median !== w.med) report_mismatch("median", o_median, w.med);
                if (o_range_low !== w.lo) report_mismatch("range_low", o_range_low, w.lo);
                if (o_range_high !== w.hi) report_mismatch("range_high", o_range_high, w.hi);
                if (o_activity !== w.act) report_mismatch("activity", o_activity, w.act);
                if (o_picked !== w.picked) report_mismatch("picked", o_picked, w.picked);
                if (o_given_id !== w.id) report_mismatch("given_id", o_given_id, w.id);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(logic mode, logic [2:0] c, logic [POS_W-1:0] smp,
                             bit typed, t_tracker_result typed_res);
        t_tracker_result p;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode = mode;
        i_channel = c;
        i_sample = smp;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        p = track_item(mode, c, smp);
        expected_results.insert(expected_results.size(), typed ? typed_res : p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_channels(logic [CFG_W-1:0] v);
        drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_CHANNELS_IN_USE;
        pwdata = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        chans_cfg = v;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_segment(int count, logic [CFG_W-1:0] v);
        int n, pool[$];
        logic [POS_W-1:0] smp;
        logic [2:0] c;
        write_channels(v);
        n = (v > NCH) ? NCH : v;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) == 0) begin
                send_item(MODE_PICK, 3'($urandom), 12'($urandom), 1'b0, '0);
            end else begin
                pool.delete();
                for (int i = 0; i < n; i++) if (!owned[i]) pool.insert(pool.size(), i);
                if (pool.size() != 0 && $urandom_range(0, 99) < 88)
                    c = 3'(pool[$urandom_range(0, pool.size() - 1)]);
                else
                    c = 3'($urandom);
                case ($urandom_range(0, 9))
                    0: smp = '0;
                    1: smp = POS_MAX;
                    default: smp = 12'($urandom);
                endcase
                send_item(MODE_SAMPLE, c, smp, 1'b0, '0);
            end
        end
    endtask

    t_dir_row dir_rows[$];

    initial begin
        t_dir_row row;
        for (int i = 0; i < NCH; i++) begin
            win_fill[i] = 0;
            low_pos[i] = POS_MAX;
            high_pos[i] = '0;
            prev_med[i] = '0;
            med_seen[i] = 1'b0;
            act_sum[i] = '0;
            owned[i] = 1'b0;
        end
        id_next = '0;
        chans_cfg = CFG_RST;

        dir_rows = '{
            '{0, MODE_PICK,   3'd5, 12'hABC, 1, 1, '0},
            '{0, MODE_SAMPLE, 3'd7, POS_MAX, 1, 1, '{3'd7, 0, 0, POS_MAX, 0, 0, 0, 0}},
            '{0, MODE_SAMPLE, 3'd3, '0, WIN, 1, '{3'd3, 1, 0, 0, 0, 0, 0, 0}},
            '{0, MODE_SAMPLE, 3'd3, POS_MAX, WIN, 1,
              '{3'd3, 1, POS_MAX, 0, POS_MAX, 24'd4095, 0, 0}},
            '{0, MODE_PICK,   3'd0, '0, 1, 1, '{3'd3, 0, 0, 0, POS_MAX, 24'd4095, 1, 0}},
            '{0, MODE_SAMPLE, 3'd3, 12'd100, 1, 1, '{3'd3, 0, 0, 0, POS_MAX, 0, 0, 0}},
            '{0, MODE_SAMPLE, 3'd1, 12'h555, 10, 0, '0},
            '{0, MODE_SAMPLE, 3'd1, 12'hAAA, 11, 0, '0},
            '{1, MODE_SAMPLE, 3'd0, 12'd2, 1, 0, '0},
            '{0, MODE_SAMPLE, 3'd5, 12'd77, 1, 1, '{3'd5, 0, 0, POS_MAX, 0, 0, 0, 0}},
            '{0, MODE_PICK,   3'd0, '0, 1, 0, '0}
        };

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.is_cfg)
                write_channels(row.smp[CFG_W-1:0]);
            else
                for (int k = 0; k < row.reps; k++)
                    send_item(row.mode, row.chan, row.smp,
                              row.typed && k == row.reps - 1, row.res);
        end

        send_idle_pct = 28; recv_idle_pct = 56;
        random_segment(SEG_ITEMS, 4'd15);
        random_segment(SEG_ITEMS, 4'd1);
        send_idle_pct = 56; recv_idle_pct = 28;
        random_segment(SEG_ITEMS / 5, 4'd0);
        random_segment(SEG_ITEMS, 4'd6);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_segment(SEG_ITEMS, 4'd8);
        random_segment(SEG_ITEMS, 4'd4);

        drain();
        repeat (300) @(negedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/pmrt_pkg.sv
rtl/pmrt_ctrl.sv
rtl/pmrt_dp.sv
rtl/per_channel_median_range_tracker.sv
tb/tb_top.sv
